>>> hdl/lcc_pkg.sv
// Shared types and constants for the Luhn card number classifier.
`default_nettype none

package lcc_pkg;

  // Width of the binary card number.
  localparam int unsigned CARD_W         = 54;
  // Decimal digits needed to hold any 54-bit value.
  localparam int unsigned BCD_DIGITS     = 17;
  localparam int unsigned BCD_W          = 4 * BCD_DIGITS;
  // Digit positions that enter the checksum.
  localparam int unsigned DIGIT_COUNT    = 16;
  // Binary bits converted by each double-dabble stage.
  localparam int unsigned BITS_PER_STAGE = 6;
  localparam int unsigned DABBLE_STAGES  = CARD_W / BITS_PER_STAGE;

  // Partial digit sums over groups of four digits.
  localparam int unsigned GROUP_DIGITS   = 4;
  localparam int unsigned GROUP_COUNT    = DIGIT_COUNT / GROUP_DIGITS;
  localparam int unsigned PSUM_W         = 6;
  localparam int unsigned SUM_W          = 8;

  // Decimal digit codes used by the prefix rules.
  localparam logic [3:0] DIG_0 = 4'd0;
  localparam logic [3:0] DIG_1 = 4'd1;
  localparam logic [3:0] DIG_3 = 4'd3;
  localparam logic [3:0] DIG_4 = 4'd4;
  localparam logic [3:0] DIG_5 = 4'd5;
  localparam logic [3:0] DIG_7 = 4'd7;

  // Brand codes on the result channel.
  typedef enum logic [1:0] {
    BRAND_INVALID = 2'd0,
    BRAND_LEAD4   = 2'd1,
    BRAND_LEAD5X  = 2'd2,
    BRAND_LEAD3X  = 2'd3
  } brand_e;

  // Conversion state carried between double-dabble stages.
  typedef struct packed {
    logic [BCD_W-1:0]  bcd;
    logic [CARD_W-1:0] bin;
  } dab_t;

endpackage

`default_nettype wire

>>> hdl/luhn_card_number_classifier_top.sv
// Top level of the Luhn card number classifier pipeline.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   input   | in        | in_valid_i, in_stall_o | card_number_i[53:0]
//   result  | out       | out_valid_o, out_stall_i | brand_o[1:0], checksum_ok_o
//
// One card number can be taken every cycle while the input is not stalled; each gives one result.
// The pipeline has 9 double-dabble stages of 6 bits each plus 3 checksum stages.
// Reset clears all valid bits; payload registers are not reset.
// A stalled result holds its stage; earlier stages keep filling empty slots, so
// the input stalls only once every stage ahead of it holds an item.
`default_nettype none

module luhn_card_number_classifier_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [lcc_pkg::CARD_W-1:0] card_number_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [1:0]                      brand_o,
  output logic                            checksum_ok_o
);

  logic            dab_valid [lcc_pkg::DABBLE_STAGES+1];
  logic            dab_ready [lcc_pkg::DABBLE_STAGES+1];
  lcc_pkg::dab_t   dab_data  [lcc_pkg::DABBLE_STAGES+1];
  lcc_pkg::brand_e brand;

  // Conversion starts with an empty BCD word and the binary number.
  assign dab_valid[0]    = in_valid_i;
  assign dab_data[0].bcd = '0;
  assign dab_data[0].bin = card_number_i;
  assign in_stall_o      = !dab_ready[0];

  // Double-dabble pipeline.
  for (genvar s = 0; s < lcc_pkg::DABBLE_STAGES; s++) begin : g_dab
    lcc_dabble u_dabble (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (dab_valid[s]),
      .in_data_i   (dab_data[s]),
      .in_ready_o  (dab_ready[s]),
      .out_valid_o (dab_valid[s+1]),
      .out_data_o  (dab_data[s+1]),
      .out_ready_i (dab_ready[s+1])
    );
  end

  // Checksum and prefix stages.
  lcc_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (dab_valid[lcc_pkg::DABBLE_STAGES]),
    .bcd_i         (dab_data[lcc_pkg::DABBLE_STAGES].bcd),
    .in_ready_o    (dab_ready[lcc_pkg::DABBLE_STAGES]),
    .out_valid_o   (out_valid_o),
    .brand_o       (brand),
    .checksum_ok_o (checksum_ok_o),
    .out_stall_i   (out_stall_i)
  );

  assign brand_o = brand;

endmodule

`default_nettype wire

>>> hdl/lcc_dabble.sv
// One pipeline stage of the binary to BCD converter (several shift-add-3 steps).
`default_nettype none

module lcc_dabble (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire lcc_pkg::dab_t in_data_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output lcc_pkg::dab_t      out_data_o,
  input  wire logic          out_ready_i
);

  logic          valid_q;
  lcc_pkg::dab_t data_d;
  lcc_pkg::dab_t data_q;

  // Stage takes a new transfer when empty or when its content moves on.
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Shift-add-3 steps: adjust every digit of five or more, then shift one bit in.
  always_comb begin
    data_d = in_data_i;
    for (int it = 0; it < lcc_pkg::BITS_PER_STAGE; it++) begin
      for (int dg = 0; dg < lcc_pkg::BCD_DIGITS; dg++) begin
        if (data_d.bcd[dg*4 +: 4] >= 4'd5) begin
          data_d.bcd[dg*4 +: 4] = data_d.bcd[dg*4 +: 4] + 4'd3;
        end
      end
      {data_d.bcd, data_d.bin} = {data_d.bcd[lcc_pkg::BCD_W-2:0], data_d.bin, 1'b0};
    end
  end

  // Valid bit of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/lcc_check.sv
// Luhn digit sum, modulo-10 test and brand prefix decode over three stages.
`default_nettype none

module lcc_check (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic [lcc_pkg::BCD_W-1:0]  bcd_i,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  output lcc_pkg::brand_e                 brand_o,
  output logic                            checksum_ok_o,
  input  wire logic                       out_stall_i
);

  // Value a digit adds to the Luhn sum; doubled digits fold back above nine.
  function automatic logic [3:0] luhn_val(input logic [3:0] dig, input logic dbl);
    logic [4:0] two;
    two = {dig, 1'b0};
    if (!dbl) begin
      luhn_val = dig;
    end else if (two > 5'd9) begin
      luhn_val = 4'(two - 5'd9);
    end else begin
      luhn_val = two[3:0];
    end
  endfunction

  // Remainder by ten for a sum below 160, by conditional subtraction.
  function automatic logic [3:0] mod10(input logic [lcc_pkg::SUM_W-1:0] val);
    logic [lcc_pkg::SUM_W-1:0] r;
    r = val;
    if (r >= 8'd80) r = r - 8'd80;
    if (r >= 8'd40) r = r - 8'd40;
    if (r >= 8'd20) r = r - 8'd20;
    if (r >= 8'd10) r = r - 8'd10;
    mod10 = r[3:0];
  endfunction

  logic [3:0]                  dig [lcc_pkg::BCD_DIGITS];
  logic [lcc_pkg::PSUM_W-1:0]  psum_d [lcc_pkg::GROUP_COUNT];
  lcc_pkg::brand_e             brand1_d;

  logic                        v1_q;
  logic [lcc_pkg::PSUM_W-1:0]  psum_q [lcc_pkg::GROUP_COUNT];
  lcc_pkg::brand_e             brand1_q;
  logic                        v2_q;
  logic [lcc_pkg::SUM_W-1:0]   sum_d;
  logic [lcc_pkg::SUM_W-1:0]   sum_q;
  lcc_pkg::brand_e             brand2_q;
  logic                        v3_q;
  lcc_pkg::brand_e             brand3_q;
  logic                        ok3_q;

  logic                        ready1;
  logic                        ready2;
  logic                        ready3;

  // Ready chain lets a stalled result keep its place while bubbles fill.
  assign ready3     = !v3_q || !out_stall_i;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign in_ready_o = ready1;

  // Split the BCD word into digits.
  always_comb begin
    for (int i = 0; i < lcc_pkg::BCD_DIGITS; i++) begin
      dig[i] = bcd_i[i*4 +: 4];
    end
  end

  // Stage one: partial Luhn sums over four-digit groups.
  always_comb begin
    for (int g = 0; g < lcc_pkg::GROUP_COUNT; g++) begin
      psum_d[g] = '0;
      for (int k = 0; k < lcc_pkg::GROUP_DIGITS; k++) begin
        psum_d[g] = psum_d[g] +
          lcc_pkg::PSUM_W'(luhn_val(dig[g*lcc_pkg::GROUP_DIGITS + k], k[0]));
      end
    end
  end

  // Stage one: prefix rules in priority order, on the leading decimal digits.
  always_comb begin
    brand1_d = lcc_pkg::BRAND_INVALID;
    if ((dig[16] == lcc_pkg::DIG_0 && dig[15] == lcc_pkg::DIG_0 &&
         dig[14] == lcc_pkg::DIG_0 && dig[13] == lcc_pkg::DIG_0 &&
         dig[12] == lcc_pkg::DIG_4) ||
        (dig[16] == lcc_pkg::DIG_0 && dig[15] == lcc_pkg::DIG_4)) begin
      brand1_d = lcc_pkg::BRAND_LEAD4;
    end else if (dig[16] == lcc_pkg::DIG_0 && dig[15] == lcc_pkg::DIG_5 &&
                 dig[14] >= lcc_pkg::DIG_1 && dig[14] <= lcc_pkg::DIG_5) begin
      brand1_d = lcc_pkg::BRAND_LEAD5X;
    end else if (dig[16] == lcc_pkg::DIG_0 && dig[15] == lcc_pkg::DIG_0 &&
                 dig[14] == lcc_pkg::DIG_3 &&
                 (dig[13] == lcc_pkg::DIG_4 || dig[13] == lcc_pkg::DIG_7)) begin
      brand1_d = lcc_pkg::BRAND_LEAD3X;
    end
  end

  // Stage two: total of the partial sums.
  always_comb begin
    sum_d = '0;
    for (int g = 0; g < lcc_pkg::GROUP_COUNT; g++) begin
      sum_d = sum_d + lcc_pkg::SUM_W'(psum_q[g]);
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) v1_q <= in_valid_i;
      if (ready2) v2_q <= v1_q;
      if (ready3) v3_q <= v2_q;
    end
  end

  // Payload registers; stage three gates the brand with the checksum.
  always_ff @(posedge clk_i) begin
    if (ready1) begin
      psum_q   <= psum_d;
      brand1_q <= brand1_d;
    end
    if (ready2) begin
      sum_q    <= sum_d;
      brand2_q <= brand1_q;
    end
    if (ready3) begin
      ok3_q    <= (mod10(sum_q) == 4'd0);
      brand3_q <= (mod10(sum_q) == 4'd0) ? brand2_q : lcc_pkg::BRAND_INVALID;
    end
  end

  assign out_valid_o   = v3_q;
  assign brand_o       = brand3_q;
  assign checksum_ok_o = ok3_q;

endmodule

`default_nettype wire

>>> hdl/lcc_checker.sv
// Port-level checks of the classifier and their binding to the top level.
`default_nettype none

module lcc_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic [lcc_pkg::CARD_W-1:0] card_number_i,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [1:0]                 brand_o,
  input wire logic                       checksum_ok_o
);

  // No result is shown while reset is held.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // A brand is only given to a number that passes the checksum.
  a_brand_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && brand_o != lcc_pkg::BRAND_INVALID) |-> checksum_ok_o)
    else $error("brand given with failed checksum");

  // With the result side free, the input side never stalls.
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled while the result side moves");

  // A stalled card number is held until its transfer.
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(card_number_i)))
    else $error("stalled card number changed");

  // A stalled result holds its payload.
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(brand_o) && $stable(checksum_ok_o)))
    else $error("stalled result changed");

endmodule

bind luhn_card_number_classifier_top lcc_checker u_lcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .card_number_i (card_number_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .brand_o       (brand_o),
  .checksum_ok_o (checksum_ok_o)
);

`default_nettype wire
